// File: sv/receive_ring_buffer_unit_macros.svh
// Assertion macros for the receive ring buffer unit.
`ifndef RECEIVE_RING_BUFFER_UNIT_MACROS_SVH
`define RECEIVE_RING_BUFFER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RRB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RRB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rrb_pkg.sv
// Shared constants and types for the receive ring buffer unit.
package rrb_pkg;

    localparam int DEPTH_DEF = 256;

    localparam int KIND_W  = 2;
    localparam int DATA_W  = 8;
    localparam int COUNT_W = 9;
    localparam int SIZE_W  = 9;
    localparam int CONT_W  = 9;
    localparam int RIDX_W  = 8;

    localparam logic [SIZE_W-1:0] BUF_SIZE_RESET = 9'd256;

    localparam logic [KIND_W-1:0] KIND_PUSH    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FLUSH   = 2'd3;

    // Commands from controller to datapath.
    typedef struct packed {
        logic accept;   // input word taken this cycle: execute the operation
        logic load;     // capture the result into the output register
    } cmd_t;

endpackage

// File: sv/receive_ring_buffer_unit.sv
// Receive ring buffer unit: stream in, stream out, one size register.
//
// Each input word is one operation on a byte ring buffer: push, pop, release
// or flush, selected by s_tuser. Every operation returns exactly one word on
// the m_ channel with the popped byte (if any), the bytes readable from the
// read index without wrapping, and the read index, all taken after the op.
// A result reaches the m_ channel through the byte store's output register and
// then the result register, whose load waits while an untaken word is held.
// Only one operation is in flight at a time: the byte store is read on the
// accept cycle and its registered output is copied into the result register
// when the load is issued.
// The result register decouples the sides: s_tready rises in the cycle the
// result is loaded, together with m_tvalid, even while m_tvalid waits on
// m_tready. If the receiver stalls with a result held, the next op executes
// but waits to load its result.
// Reset (aresetn low, synchronous) zeroes both indices, sets the size register
// to 256 and drops m_tvalid; the byte store keeps its contents.
// cfg_wr_en writes buffer_size; write only while no operation is pending.
module receive_ring_buffer_unit #(
    parameter int DEPTH = rrb_pkg::DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data[7:0], count[16:8], zero pad
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_data[7:0], contiguous_available[16:8],
                                   // read_index[24:17], zero pad
    output logic [0:0]  m_tuser,   // read_valid[0]
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data
);

`include "receive_ring_buffer_unit_macros.svh"

    rrb_pkg::cmd_t cmd;

    logic                               read_valid;
    logic [rrb_pkg::DATA_W-1:0]         read_data;
    logic [rrb_pkg::CONT_W-1:0]         contiguous_available;
    logic [rrb_pkg::RIDX_W-1:0]         read_index;

    rrb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    rrb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .kind                 (s_tuser),
        .data                 (s_tdata[7:0]),
        .count                (s_tdata[16:8]),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data),
        .read_valid           (read_valid),
        .read_data            (read_data),
        .contiguous_available (contiguous_available),
        .read_index           (read_index)
    );

    assign m_tdata = {7'd0, read_index, contiguous_available, read_data};
    assign m_tuser = read_valid;

    `RRB_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second word accepted while an operation is in flight")
    `RRB_ASSERT_NOW(a_no_overwrite, aclk, aresetn, cmd.load, !m_tvalid || m_tready, "result loaded over an untaken word")
    `RRB_ASSERT_NOW(a_idle_data_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[7:0] == 8'd0, "read_data non-zero without a popped byte")

endmodule

// File: sv/rrb_datapath.sv
// Datapath of the receive ring buffer: indices, byte store and result register.
module rrb_datapath #(
    parameter int DEPTH = rrb_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rrb_pkg::cmd_t                 cmd,
    input  logic [rrb_pkg::KIND_W-1:0]    kind,
    input  logic [rrb_pkg::DATA_W-1:0]    data,
    input  logic [rrb_pkg::COUNT_W-1:0]   count,
    input  logic                          cfg_wr_en,
    input  logic [rrb_pkg::SIZE_W-1:0]    cfg_wr_data,
    output logic                          read_valid,
    output logic [rrb_pkg::DATA_W-1:0]    read_data,
    output logic [rrb_pkg::CONT_W-1:0]    contiguous_available,
    output logic [rrb_pkg::RIDX_W-1:0]    read_index
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int CMP_W = (CNT_W > rrb_pkg::SIZE_W) ? CNT_W : rrb_pkg::SIZE_W;
    localparam int SUM_W = CNT_W + 1;

    logic [rrb_pkg::DATA_W-1:0] byte_store [DEPTH];

    logic [rrb_pkg::SIZE_W-1:0] buffer_size_reg;
    logic [IDX_W-1:0]           wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]           rd_idx_reg, rd_idx_next;
    logic [rrb_pkg::DATA_W-1:0] mem_q_reg;
    logic                       pop_ok_reg, pop_ok_next;

    logic                       out_valid_reg;
    logic [rrb_pkg::DATA_W-1:0] out_data_reg;
    logic [rrb_pkg::CONT_W-1:0] out_cont_reg;
    logic [rrb_pkg::RIDX_W-1:0] out_ridx_reg;

    logic [CMP_W-1:0] size_ext;
    logic [CMP_W-1:0] eff_cmp;
    logic [CNT_W-1:0] eff_size;
    logic [CNT_W-1:0] cont;
    logic [CNT_W-1:0] run;
    logic [CNT_W-1:0] rel_cnt;
    logic [SUM_W-1:0] rel_sum;
    logic [CNT_W-1:0] wr_inc;
    logic [CNT_W-1:0] rd_inc;
    logic             not_empty;

    // Clamp the configured size into 1..DEPTH.
    always_comb begin
        size_ext = CMP_W'(buffer_size_reg);
        if (size_ext == '0) begin
            eff_cmp = CMP_W'(1);
        end else if (size_ext > CMP_W'(DEPTH)) begin
            eff_cmp = CMP_W'(DEPTH);
        end else begin
            eff_cmp = size_ext;
        end
        eff_size = CNT_W'(eff_cmp);
    end

    // Bytes readable from the read index without wrapping.
    always_comb begin
        if (rd_idx_reg <= wr_idx_reg) begin
            cont = CNT_W'(wr_idx_reg) - CNT_W'(rd_idx_reg);
        end else if (CNT_W'(rd_idx_reg) >= eff_size) begin
            cont = '0;
        end else begin
            cont = eff_size - CNT_W'(rd_idx_reg);
        end
    end

    assign not_empty = (wr_idx_reg != rd_idx_reg);
    assign run       = not_empty ? cont : '0;
    assign rel_cnt   = (CMP_W'(count) > CMP_W'(run)) ? run : CNT_W'(count);
    assign rel_sum   = SUM_W'(rd_idx_reg) + SUM_W'(rel_cnt);
    assign wr_inc    = CNT_W'(wr_idx_reg) + CNT_W'(1);
    assign rd_inc    = CNT_W'(rd_idx_reg) + CNT_W'(1);

    always_comb begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        pop_ok_next = 1'b0;
        if (cmd.accept) begin
            unique case (kind)
                rrb_pkg::KIND_PUSH: begin
                    wr_idx_next = (wr_inc >= eff_size) ? '0 : IDX_W'(wr_inc);
                end
                rrb_pkg::KIND_POP: begin
                    if (not_empty) begin
                        pop_ok_next = 1'b1;
                        rd_idx_next = (rd_inc >= eff_size) ? '0 : IDX_W'(rd_inc);
                    end
                end
                rrb_pkg::KIND_RELEASE: begin
                    rd_idx_next = (rel_sum >= SUM_W'(eff_size)) ? '0 : IDX_W'(rel_sum);
                end
                rrb_pkg::KIND_FLUSH: begin
                    wr_idx_next = '0;
                    rd_idx_next = '0;
                end
                default: begin
                    wr_idx_next = wr_idx_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_size_reg <= rrb_pkg::BUF_SIZE_RESET;
            wr_idx_reg      <= '0;
            rd_idx_reg      <= '0;
            pop_ok_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                buffer_size_reg <= cfg_wr_data;
            end
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            if (cmd.accept) begin
                pop_ok_reg <= pop_ok_next;
            end
        end
    end

    // Byte store: write on push, read the oldest byte on accept.
    always_ff @(posedge aclk) begin
        if (cmd.accept && kind == rrb_pkg::KIND_PUSH) begin
            byte_store[wr_idx_reg] <= data;
        end
        if (cmd.accept) begin
            mem_q_reg <= byte_store[rd_idx_reg];
        end
    end

    // Result register: indices have already advanced when load is issued.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_valid_reg <= pop_ok_reg;
            out_data_reg  <= pop_ok_reg ? mem_q_reg : '0;
            out_cont_reg  <= rrb_pkg::CONT_W'(cont);
            out_ridx_reg  <= rrb_pkg::RIDX_W'(rd_idx_reg);
        end
    end

    assign read_valid           = out_valid_reg;
    assign read_data            = out_data_reg;
    assign contiguous_available = out_cont_reg;
    assign read_index           = out_ridx_reg;

endmodule

// File: sv/rrb_ctrl.sv
// Controller of the receive ring buffer: input acceptance and output handshake.
module rrb_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output rrb_pkg::cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.accept = (state_reg == ST_IDLE) && s_tvalid;
    // Load only once the output register is free or being drained.
    assign cmd.load   = (state_reg == ST_RESP) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (cmd.load) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule
